### rtl/huffman_code_emitter_macros.svh
// assertion macros shared by the emitter modules
`ifndef HUFFMAN_CODE_EMITTER_MACROS_SVH
`define HUFFMAN_CODE_EMITTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HCE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define HCE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define HCE_ASSERT_IMPLIES(label, ante, cons, msg)
`define HCE_ASSERT_NEXT(label, ante, cons, msg)
`define HCE_ASSERT_ALWAYS(label, cond, msg)

`endif

`endif

### rtl/hce_pkg.sv
package hce_pkg;

    localparam int BYTE_W      = 8;
    localparam int SYMBOL_W    = 8;
    localparam int WORD_W      = 32;
    localparam int LEN_W       = 6;
    localparam int PEND_W      = 7;
    localparam int CNT_W       = 3;
    localparam int TABLE_DEPTH = 256;
    localparam int IN_DATA_W   = 48;
    localparam int MODE_W      = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EMIT,
        ST_UNKNOWN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic take;
        logic prep;
        logic emit_byte;
        logic emit_unknown;
        logic emit_flush;
    } cmd_t;

    typedef struct packed {
        mode_t in_mode;
        logic  pending_empty;
        logic  len_zero;
        logic  byte_ready;
        logic  out_free;
    } status_t;

endpackage

### rtl/huffman_code_emitter.sv
// channel | dir | tdata (low bit up)                               | tuser          | tlast
// s_*     | in  | symbol[7:0] code_word[39:8] code_length[45:40]   | mode[1:0]      | -
// m_*     | out | packed_byte[7:0]                                 | from_flush[0]  | last_of_run
//         |     |                                                  | unknown_sym[1] |
// one request is handled at a time; s_tready is high only while the controller waits
// load, unused mode and empty flush stay in idle; flush with pending bits adds a flush step
// encode gives 0 to 4 output bytes in steps: table read, alignment, one byte per cycle
// via the single output register while it is free, then a final check
// m_tready low holds the output register and stalls the byte sequence
// reset clears the pending bits and the per-symbol written flags; no clearing pass
module huffman_code_emitter
    import hce_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // symbol, code_word, code_length, zero pad
    input  logic [MODE_W-1:0]    s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,   // packed_byte
    output logic                 m_tlast,
    output logic [1:0]           m_tuser    // from_flush, unknown_symbol
);

    localparam int CODE_W = (MAX_CODE_LEN > WORD_W) ? WORD_W : MAX_CODE_LEN;

    cmd_t    cmd;
    status_t sts;

    hce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hce_datapath #(
        .CODE_W (CODE_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

### rtl/hce_datapath.sv
`include "huffman_code_emitter_macros.svh"

module hce_datapath
    import hce_pkg::*;
#(
    parameter int CODE_W = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [MODE_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,
    output logic                 m_tlast,
    output logic [1:0]           m_tuser,
    input  cmd_t                 cmd,
    output status_t              sts
);

    localparam int ACC_W   = CODE_W + PEND_W;
    localparam int TOT_W   = $clog2(ACC_W + 1);
    localparam int ENTRY_W = LEN_W + CODE_W;

    logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [ENTRY_W-1:0]     rd_entry_reg;
    logic                   rd_vld_reg;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;

    logic              out_vld_reg, out_vld_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic [1:0]        out_user_reg, out_user_next;

    logic [SYMBOL_W-1:0] in_sym;
    logic [WORD_W-1:0]   in_word;
    logic [LEN_W-1:0]    in_len;
    logic [LEN_W-1:0]    len_sat;
    logic                load_we;

    logic [LEN_W-1:0]  rd_len;
    logic [CODE_W-1:0] rd_code;
    logic [ACC_W-1:0]  code_mask;
    logic [ACC_W-1:0]  shifted;
    logic [TOT_W-1:0]  total_sum;
    logic [CNT_W-1:0]  rem;
    logic              out_free;

    assign in_sym  = s_tdata[SYMBOL_W-1:0];
    assign in_word = s_tdata[SYMBOL_W +: WORD_W];
    assign in_len  = s_tdata[SYMBOL_W + WORD_W +: LEN_W];
    assign len_sat = (in_len > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : in_len;
    assign load_we = cmd.take && (mode_t'(s_tuser) == MODE_LOAD);

    // table: length and code together, read registered on every request
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[in_sym] <= {len_sat, in_word[CODE_W-1:0]};
        end
        rd_entry_reg <= mem[in_sym];
    end

    // written flags stand in for the cleared length table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (load_we)
            begin
                vld_reg[in_sym] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[in_sym];
        end
    end

    assign rd_len  = rd_vld_reg ? rd_entry_reg[ENTRY_W-1 -: LEN_W] : '0;
    assign rd_code = rd_entry_reg[CODE_W-1:0];

    assign code_mask = ~({ACC_W{1'b1}} << rd_len);
    assign shifted   = (ACC_W'(pend_bits_reg) << rd_len) | (ACC_W'(rd_code) & code_mask);
    assign total_sum = TOT_W'(pend_cnt_reg) + TOT_W'(rd_len);
    assign rem       = total_sum[CNT_W-1:0];
    assign out_free  = !out_vld_reg || m_tready;

    always_comb
    begin
        acc_next       = acc_reg;
        total_next     = total_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;

        if (cmd.prep)
        begin
            // left-align so the next byte always sits at the top
            acc_next       = shifted << (TOT_W'(ACC_W) - total_sum);
            total_next     = total_sum;
            pend_bits_next = shifted[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
            pend_cnt_next  = rem;
        end

        if (cmd.emit_byte)
        begin
            out_vld_next  = 1'b1;
            out_data_next = acc_reg[ACC_W-1 -: BYTE_W];
            out_last_next = ((total_reg - TOT_W'(BYTE_W)) < TOT_W'(BYTE_W));
            out_user_next = 2'b00;
            acc_next      = acc_reg << BYTE_W;
            total_next    = total_reg - TOT_W'(BYTE_W);
        end

        if (cmd.emit_unknown)
        begin
            out_vld_next  = 1'b1;
            out_data_next = '0;
            out_last_next = 1'b1;
            out_user_next = 2'b10;
        end

        if (cmd.emit_flush)
        begin
            out_vld_next   = 1'b1;
            out_data_next  = BYTE_W'({1'b0, pend_bits_reg} << (3'd0 - pend_cnt_reg));
            out_last_next  = 1'b1;
            out_user_next  = 2'b01;
            pend_bits_next = '0;
            pend_cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    assign sts.in_mode       = mode_t'(s_tuser);
    assign sts.pending_empty = (pend_cnt_reg == '0);
    assign sts.len_zero      = (rd_len == '0);
    assign sts.byte_ready    = (total_reg >= TOT_W'(BYTE_W));
    assign sts.out_free      = out_free;

    `HCE_ASSERT_IMPLIES(a_emit_has_byte, cmd.emit_byte, total_reg >= TOT_W'(BYTE_W), "byte emitted without eight bits")
    `HCE_ASSERT_NEXT(a_emit_shows, cmd.emit_byte || cmd.emit_unknown || cmd.emit_flush, m_tvalid, "result lost")
    `HCE_ASSERT_ALWAYS(a_total_range, total_reg <= TOT_W'(ACC_W), "bit count beyond accumulator")

endmodule

### rtl/hce_ctrl.sv
`include "huffman_code_emitter_macros.svh"

module hce_ctrl
    import hce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (sts.in_mode)
                        MODE_ENCODE: state_next = ST_PREP;
                        MODE_FLUSH:  state_next = sts.pending_empty ? ST_IDLE : ST_FLUSH;
                        MODE_LOAD:   state_next = ST_IDLE;
                        MODE_NONE:   state_next = ST_IDLE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PREP:
            begin
                state_next = sts.len_zero ? ST_UNKNOWN : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!sts.byte_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UNKNOWN, ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_byte = sts.byte_ready && sts.out_free;
            end
            ST_UNKNOWN:
            begin
                cmd.emit_unknown = sts.out_free;
            end
            ST_FLUSH:
            begin
                cmd.emit_flush = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    `HCE_ASSERT_ALWAYS(a_one_action, $onehot0({cmd.prep, cmd.emit_byte, cmd.emit_unknown, cmd.emit_flush}), "conflicting datapath commands")
    `HCE_ASSERT_IMPLIES(a_emit_room, cmd.emit_byte || cmd.emit_unknown || cmd.emit_flush, sts.out_free, "emit into a full output register")
    `HCE_ASSERT_NEXT(a_empty_flush, cmd.take && sts.in_mode == MODE_FLUSH && sts.pending_empty, state_reg == ST_IDLE, "flush with nothing pending went busy")

endmodule
